/* sv/epoch_seconds_to_calendar_macros.svh */
// assertion macros for the calendar converter
`ifndef EPOCH_SECONDS_TO_CALENDAR_MACROS_SVH
`define EPOCH_SECONDS_TO_CALENDAR_MACROS_SVH

// same-cycle implication, checked outside reset
`define ESC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("calendar converter check failed");

// next-cycle implication, checked outside reset
`define ESC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("calendar converter check failed");

`endif

/* sv/esc_pkg.sv */
package esc_pkg;

    localparam int unsigned ZoneW = 17;
    localparam logic [ZoneW-1:0] ZONE_RESET = 17'd3600;

    localparam int unsigned QueueDepth = 2;

    // exact reciprocals: floor(x/d) = (x*ceil(2^k/d)) >> k for the stated x range
    localparam longint unsigned DayMulL  = ((64'd1 << 35) + 64'd674) / 64'd675;
    localparam longint unsigned HourMulL = ((64'd1 << 29) + 64'd3599) / 64'd3600;
    localparam longint unsigned MinMulL  = ((64'd1 << 23) + 64'd59) / 64'd60;
    localparam longint unsigned BMulL    = ((64'd1 << 42) + 64'd146096) / 64'd146097;
    localparam longint unsigned DMulL    = ((64'd1 << 31) + 64'd1460) / 64'd1461;
    localparam longint unsigned MMulL    = ((64'd1 << 19) + 64'd152) / 64'd153;
    localparam longint unsigned WMulL    = ((64'd1 << 19) + 64'd6) / 64'd7;

    localparam logic [25:0] DAY_MUL  = 26'(DayMulL);
    localparam logic [17:0] HOUR_MUL = 18'(HourMulL);
    localparam logic [17:0] MIN_MUL  = 18'(MinMulL);
    localparam logic [24:0] B_MUL    = 25'(BMulL);
    localparam logic [20:0] D_MUL    = 21'(DMulL);
    localparam logic [11:0] M_MUL    = 12'(MMulL);
    localparam logic [16:0] W_MUL    = 17'(WMulL);

    localparam logic [21:0] A_OFFSET   = 22'd2472632; // epoch jdn plus 32044
    localparam logic [15:0] DOW_OFFSET = 16'd3;       // epoch jdn mod 7
    localparam logic [15:0] YEAR_BASE  = 16'd4800;

    typedef struct packed {
        logic [4:0] hour_num;
        logic [5:0] minute_num;
        logic [5:0] second_num;
        logic [2:0] day_of_week;
    } tod_t;

    // (153*m + 2) / 5 for the shifted month m
    function automatic logic [8:0] month_start(input logic [3:0] m);
        logic [8:0] r;
        case (m)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd31;
            4'd2:    r = 9'd61;
            4'd3:    r = 9'd92;
            4'd4:    r = 9'd122;
            4'd5:    r = 9'd153;
            4'd6:    r = 9'd184;
            4'd7:    r = 9'd214;
            4'd8:    r = 9'd245;
            4'd9:    r = 9'd275;
            4'd10:   r = 9'd306;
            4'd11:   r = 9'd337;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

/* sv/epoch_seconds_to_calendar.sv */
// unix timestamp to gregorian calendar converter. each input beat carries a 32-bit
// unix second count; the zone offset register (signed 17 bits, reset 3600) is
// subtracted modulo 2^32 and one output beat gives year, month, day of month, day of
// week (0 monday) and hour/minute/second. one beat is taken every clock cycle when
// the output side keeps up. an accepted beat passes the front register, the queue and
// the back pipeline, whose depth is set by its chain of constant divisions done as
// reciprocal multiplies. the back pipeline holds as a whole while its last stage
// waits, and the two-entry queue absorbs the front's in-flight beat. the zone
// offset may be written at any time when the block is idle; cfg_ready is always high
module epoch_seconds_to_calendar (
    input  logic                      clk,
    input  logic                      rst_n,
    // configuration channel
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [esc_pkg::ZoneW-1:0] zone_offset_seconds,
    // input channel
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [31:0]               unix_seconds,
    // output channel
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [11:0]               year_full,
    output logic [3:0]                month_num,
    output logic [4:0]                day_of_month,
    output logic [2:0]                day_of_week,
    output logic [4:0]                hour_num,
    output logic [5:0]                minute_num,
    output logic [5:0]                second_num
);

    // front to queue
    logic        push_valid;
    logic        push_ready;
    logic [31:0] push_secs;
    // queue to back
    logic        pop_valid;
    logic        pop_ready;
    logic [31:0] pop_secs;

    // front: holds the zone offset and forms local seconds
    esc_front u_front (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .zone_offset_seconds (zone_offset_seconds),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .unix_seconds        (unix_seconds),
        .push_valid          (push_valid),
        .push_ready          (push_ready),
        .push_secs           (push_secs)
    );

    // short queue so the front keeps taking beats while the back holds
    esc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_secs  (push_secs),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_secs   (pop_secs)
    );

    // back: day split, time of day and julian-day calendar conversion
    esc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_secs     (pop_secs),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .year_full    (year_full),
        .month_num    (month_num),
        .day_of_month (day_of_month),
        .day_of_week  (day_of_week),
        .hour_num     (hour_num),
        .minute_num   (minute_num),
        .second_num   (second_num)
    );

endmodule

/* sv/esc_front.sv */
module esc_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [esc_pkg::ZoneW-1:0]     zone_offset_seconds,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [31:0]                   unix_seconds,
    output logic                          push_valid,
    input  logic                          push_ready,
    output logic [31:0]                   push_secs
);

    logic [esc_pkg::ZoneW-1:0] zone_reg;
    logic                      valid_reg;
    logic [31:0]               secs_reg;
    logic [31:0]               secs_next;

    assign cfg_ready  = 1'b1;
    assign in_ready   = !valid_reg || push_ready;
    assign push_valid = valid_reg;
    assign push_secs  = secs_reg;

    // local time, wraps modulo 2^32
    assign secs_next = unix_seconds - {{(32-esc_pkg::ZoneW){zone_reg[esc_pkg::ZoneW-1]}}, zone_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zone_reg  <= esc_pkg::ZONE_RESET;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                zone_reg <= zone_offset_seconds;
            end
            if (in_ready)
            begin
                valid_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            secs_reg <= secs_next;
        end
    end

endmodule

/* sv/esc_queue.sv */
module esc_queue (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push_valid,
    output logic        push_ready,
    input  logic [31:0] push_secs,
    output logic        pop_valid,
    input  logic        pop_ready,
    output logic [31:0] pop_secs
);

    localparam int unsigned PtrW = $clog2(esc_pkg::QueueDepth);

    logic [31:0]     mem_reg [esc_pkg::QueueDepth];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [PtrW:0]   count_reg;
    logic            do_push;
    logic            do_pop;

    assign push_ready = count_reg != (PtrW+1)'(esc_pkg::QueueDepth);
    assign pop_valid  = count_reg != '0;
    assign pop_secs   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_secs;
        end
    end

endmodule

/* sv/esc_back.sv */
module esc_back (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        pop_valid,
    output logic        pop_ready,
    input  logic [31:0] pop_secs,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [11:0] year_full,
    output logic [3:0]  month_num,
    output logic [4:0]  day_of_month,
    output logic [2:0]  day_of_week,
    output logic [4:0]  hour_num,
    output logic [5:0]  minute_num,
    output logic [5:0]  second_num
);

    localparam int unsigned Stages = 8;

    logic [Stages-1:0] v_reg;
    logic              en;

    // stage registers
    logic [31:0] s1_t_reg;
    logic [15:0] s1_days_reg;
    logic [16:0] s2_sod_reg;
    logic [21:0] s2_a_reg;
    logic [15:0] s2_dw_reg;
    logic [16:0] s3_sod_reg;
    logic [21:0] s3_a_reg;
    logic [15:0] s3_dw_reg;
    logic [4:0]  s3_hour_reg;
    logic [10:0] s3_mt_reg;
    logic [6:0]  s3_b_reg;
    logic [13:0] s3_q7_reg;
    esc_pkg::tod_t s4_tod_reg, s5_tod_reg, s6_tod_reg, s7_tod_reg, s8_tod_reg;
    logic [6:0]  s4_b_reg, s5_b_reg, s6_b_reg, s7_b_reg;
    logic [17:0] s4_c_reg, s5_c_reg;
    logic [9:0]  s5_d_reg, s6_d_reg, s7_d_reg;
    logic [8:0]  s6_e_reg, s7_e_reg;
    logic [3:0]  s7_m_reg;
    logic [11:0] s8_year_reg;
    logic [3:0]  s8_month_reg;
    logic [4:0]  s8_mday_reg;

    // next values
    logic [50:0] day_prod;
    logic [15:0] s1_days_next;
    logic [32:0] sod_prod;
    logic [16:0] s2_sod_next;
    logic [34:0] hour_prod;
    logic [34:0] min_prod;
    logic [48:0] b_prod;
    logic [32:0] w_prod;
    logic [16:0] sec_prod;
    logic [10:0] mh_prod;
    logic [24:0] cb_prod;
    logic [22:0] c_diff;
    logic [15:0] w_diff;
    esc_pkg::tod_t s4_tod_next;
    logic [40:0] d_prod;
    logic [20:0] ed_prod;
    logic [18:0] e_diff;
    logic [10:0] m_in;
    logic [22:0] m_prod;
    logic [8:0]  mday_diff;
    logic [15:0] year_sum;
    logic        wrap;

    assign en        = !v_reg[Stages-1] || out_ready;
    assign pop_ready = en;

    always_comb
    begin
        // days = floor(t / 86400) = floor((t >> 7) / 675)
        day_prod     = 51'(pop_secs[31:7]) * 51'(esc_pkg::DAY_MUL);
        s1_days_next = day_prod[50:35];
        sod_prod     = 33'(s1_days_reg) * 33'd86400;
        s2_sod_next  = s1_t_reg[16:0] - sod_prod[16:0];
        hour_prod    = 35'(s2_sod_reg) * 35'(esc_pkg::HOUR_MUL);
        min_prod     = 35'(s2_sod_reg) * 35'(esc_pkg::MIN_MUL);
        b_prod       = 49'({s2_a_reg, 2'b11}) * 49'(esc_pkg::B_MUL);
        w_prod       = 33'(s2_dw_reg) * 33'(esc_pkg::W_MUL);
        sec_prod     = 17'(s3_mt_reg) * 17'd60;
        mh_prod      = 11'(s3_hour_reg) * 11'd60;
        cb_prod      = 25'(s3_b_reg) * 25'd146097;
        c_diff       = 23'(s3_a_reg) - cb_prod[24:2];
        w_diff       = s3_dw_reg - 16'(s3_q7_reg) * 16'd7;
        s4_tod_next.hour_num    = s3_hour_reg;
        s4_tod_next.minute_num  = 6'(s3_mt_reg - mh_prod);
        s4_tod_next.second_num  = 6'(s3_sod_reg - sec_prod);
        s4_tod_next.day_of_week = w_diff[2:0];
        d_prod       = 41'({s4_c_reg, 2'b11}) * 41'(esc_pkg::D_MUL);
        ed_prod      = 21'(s5_d_reg) * 21'd1461;
        e_diff       = 19'(s5_c_reg) - 19'(ed_prod[20:2]);
        m_in         = 11'(s6_e_reg) * 11'd5 + 11'd2;
        m_prod       = 23'(m_in) * 23'(esc_pkg::M_MUL);
        // shifted months ten and eleven are january and february of the next year
        wrap         = s7_m_reg >= 4'd10;
        mday_diff    = s7_e_reg - esc_pkg::month_start(s7_m_reg) + 9'd1;
        year_sum     = 16'(s7_b_reg) * 16'd100 + 16'(s7_d_reg) + 16'(wrap)
                       - esc_pkg::YEAR_BASE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[Stages-2:0], pop_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_t_reg     <= pop_secs;
            s1_days_reg  <= s1_days_next;
            s2_sod_reg   <= s2_sod_next;
            s2_a_reg     <= 22'(s1_days_reg) + esc_pkg::A_OFFSET;
            s2_dw_reg    <= s1_days_reg + esc_pkg::DOW_OFFSET;
            s3_sod_reg   <= s2_sod_reg;
            s3_a_reg     <= s2_a_reg;
            s3_dw_reg    <= s2_dw_reg;
            s3_hour_reg  <= hour_prod[33:29];
            s3_mt_reg    <= min_prod[33:23];
            s3_b_reg     <= b_prod[48:42];
            s3_q7_reg    <= w_prod[32:19];
            s4_tod_reg   <= s4_tod_next;
            s4_b_reg     <= s3_b_reg;
            s4_c_reg     <= c_diff[17:0];
            s5_tod_reg   <= s4_tod_reg;
            s5_b_reg     <= s4_b_reg;
            s5_c_reg     <= s4_c_reg;
            s5_d_reg     <= d_prod[40:31];
            s6_tod_reg   <= s5_tod_reg;
            s6_b_reg     <= s5_b_reg;
            s6_d_reg     <= s5_d_reg;
            s6_e_reg     <= e_diff[8:0];
            s7_tod_reg   <= s6_tod_reg;
            s7_b_reg     <= s6_b_reg;
            s7_d_reg     <= s6_d_reg;
            s7_e_reg     <= s6_e_reg;
            s7_m_reg     <= m_prod[22:19];
            s8_tod_reg   <= s7_tod_reg;
            s8_year_reg  <= year_sum[11:0];
            s8_month_reg <= wrap ? s7_m_reg - 4'd9 : s7_m_reg + 4'd3;
            s8_mday_reg  <= mday_diff[4:0];
        end
    end

    assign out_valid    = v_reg[Stages-1];
    assign year_full    = s8_year_reg;
    assign month_num    = s8_month_reg;
    assign day_of_month = s8_mday_reg;
    assign day_of_week  = s8_tod_reg.day_of_week;
    assign hour_num     = s8_tod_reg.hour_num;
    assign minute_num   = s8_tod_reg.minute_num;
    assign second_num   = s8_tod_reg.second_num;

endmodule

/* sv/esc_checker.sv */
`include "epoch_seconds_to_calendar_macros.svh"

module esc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [11:0] year_full,
    input logic [3:0]  month_num,
    input logic [4:0]  day_of_month,
    input logic [2:0]  day_of_week,
    input logic [4:0]  hour_num,
    input logic [5:0]  minute_num,
    input logic [5:0]  second_num
);

    // a held result beat keeps its payload
    `ESC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(year_full) && $stable(month_num) && $stable(day_of_month)
        && $stable(day_of_week) && $stable(hour_num) && $stable(minute_num)
        && $stable(second_num))

    // calendar fields in range
    `ESC_ASSERT_NOW(a_date_range, out_valid,
        month_num >= 4'd1 && month_num <= 4'd12 && day_of_month >= 5'd1
        && year_full >= 12'd1970 && year_full <= 12'd2106)

    // time of day fields in range
    `ESC_ASSERT_NOW(a_time_range, out_valid,
        hour_num <= 5'd23 && minute_num <= 6'd59 && second_num <= 6'd59
        && day_of_week <= 3'd6)

    // configuration writes never stall
    `ESC_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready)

endmodule

bind epoch_seconds_to_calendar esc_checker u_esc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .year_full    (year_full),
    .month_num    (month_num),
    .day_of_month (day_of_month),
    .day_of_week  (day_of_week),
    .hour_num     (hour_num),
    .minute_num   (minute_num),
    .second_num   (second_num)
);
